// ----- design/ptc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, widths and helpers for the pressure/temperature compensation
// pipeline and its checker.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CAL_W     = 16;
  localparam int RAW_W     = 24;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 32;
  localparam int IN_DATA_W  = 48;   // two raw fields, already whole bytes
  localparam int OUT_DATA_W = 56;   // 19 + 32 bits, padded to 7 bytes

  // Calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESSURE_SENSITIVITY  = 3'd0,
    CFG_PRESSURE_OFFSET       = 3'd1,
    CFG_SENS_TEMP_COEFF       = 3'd2,
    CFG_OFFSET_TEMP_COEFF     = 3'd3,
    CFG_REFERENCE_TEMPERATURE = 3'd4,
    CFG_TEMP_COEFF_OF_TEMP    = 3'd5
  } cfg_reg_t;

  // 20.00 C and -15.00 C expressed as offsets from 20.00 C
  localparam logic signed [18:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [18:0] VLOW_OFS  = 19'sd3500;
  localparam logic signed [17:0] VLOW_DT   = -18'sd3500;

  localparam logic signed [19:0] TEMP_MIN = -20'sd262144;
  localparam logic signed [19:0] TEMP_MAX = 20'sd262143;
  localparam logic signed [63:0] PRES_MIN = -64'sd2147483648;
  localparam logic signed [63:0] PRES_MAX = 64'sd2147483647;

  // Signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage
`default_nettype wire

// ----- design/pressure_temp_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the output is not stalled; ten register stages, each with its own valid bit.
// A stalled output holds its stage; empty stages further up keep taking items.
// Reset (rst, synchronous) clears all valid bits and the six calibration words.
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Second-order pressure and temperature compensation of raw 24-bit sensor
// conversions, using six calibration words written over the config port.
// ----------------------------------------------------------------------------
module pressure_temp_compensation (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptc_pkg::CAL_W-1:0]     cfg_data,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  wire logic [ptc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [18:0] temperature_centideg, [50:19] pressure_value, [55:51] zero
  output logic [ptc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int NSTG = 10;

  // calibration words
  logic [15:0] pressure_sensitivity;
  logic [15:0] pressure_offset;
  logic [15:0] sens_temp_coeff;
  logic [15:0] offset_temp_coeff;
  logic [15:0] reference_temperature;
  logic [15:0] temp_coeff_of_temp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_sensitivity  <= '0;
      pressure_offset       <= '0;
      sens_temp_coeff       <= '0;
      offset_temp_coeff     <= '0;
      reference_temperature <= '0;
      temp_coeff_of_temp    <= '0;
    end else if (cfg_valid) begin
      case (ptc_pkg::cfg_reg_t'(cfg_index))
        ptc_pkg::CFG_PRESSURE_SENSITIVITY:  pressure_sensitivity  <= cfg_data;
        ptc_pkg::CFG_PRESSURE_OFFSET:       pressure_offset       <= cfg_data;
        ptc_pkg::CFG_SENS_TEMP_COEFF:       sens_temp_coeff       <= cfg_data;
        ptc_pkg::CFG_OFFSET_TEMP_COEFF:     offset_temp_coeff     <= cfg_data;
        ptc_pkg::CFG_REFERENCE_TEMPERATURE: reference_temperature <= cfg_data;
        ptc_pkg::CFG_TEMP_COEFF_OF_TEMP:    temp_coeff_of_temp    <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or the stage after it loads.
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || m_axis_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NSTG-1];

  // --------------------------------------------------------------------------
  // Stage registers
  // --------------------------------------------------------------------------
  logic        [23:0] d1_1, d1_2, d1_3, d1_4, d1_5, d1_6;
  logic signed [24:0] dt_1;
  logic signed [41:0] mt_2, mo_2, ms_2;
  logic        [47:0] dtsq_2;
  logic signed [17:0] q_3;
  logic signed [35:0] off_3, off_4, off_5;
  logic signed [35:0] sens_3, sens_4, sens_5;
  logic        [16:0] tilo_3, tihi_3;
  logic signed [18:0] t2_4, t2_5, t2_6, t2_7, t2_8, t2_9, t2_10;
  logic        [34:0] sq_4, lsq_4;
  logic               low_4, vlow_4;
  logic        [37:0] offi_5, sensi_5;
  logic signed [39:0] off2_6, off2_7, off2_8;
  logic signed [38:0] sens2_6;
  logic        [43:0] plo_7;
  logic signed [43:0] phi_7;
  logic signed [62:0] prod_8;
  logic signed [42:0] diff_9;
  logic signed [31:0] p_10;

  // --------------------------------------------------------------------------
  // Combinational work of each stage
  // --------------------------------------------------------------------------
  logic signed [24:0] dt_c;
  logic signed [41:0] mt_c, mo_c, ms_c;
  logic signed [49:0] dtsq_c;
  logic        [49:0] ti3_c;
  logic signed [18:0] temp_c, lo_c;
  logic        [16:0] ti_c;
  logic signed [19:0] t2w_c;
  logic signed [18:0] t2_c;
  logic signed [35:0] qsq_c;
  logic signed [37:0] lsq_c;
  logic        [37:0] sq3_c, sq5_c, lsq7_c, lsq4_c;
  logic        [37:0] offi_c, sensi_c;
  logic        [19:0] s2lo_c;
  logic signed [18:0] s2hi_c;
  logic signed [63:0] prod_c, diff_c, pq_c;
  logic signed [31:0] p_c;

  always_comb begin
    // stage 1: temperature difference
    dt_c = $signed({1'b0, s_axis_tdata[47:24]})
         - $signed({1'b0, reference_temperature, 8'h00});

    // stage 2: first-order products
    mt_c   = dt_1 * $signed({1'b0, temp_coeff_of_temp});
    mo_c   = dt_1 * $signed({1'b0, offset_temp_coeff});
    ms_c   = dt_1 * $signed({1'b0, sens_temp_coeff});
    dtsq_c = dt_1 * dt_1;

    // stage 3 helper: 3 * dT^2
    ti3_c = {2'b00, dtsq_2} + {1'b0, dtsq_2, 1'b0};

    // stage 4: first-order temperature and correction squares
    temp_c = ptc_pkg::TEMP_BASE + 19'(q_3);
    lo_c   = 19'(q_3) + ptc_pkg::VLOW_OFS;
    ti_c   = q_3[17] ? tilo_3 : tihi_3;
    t2w_c  = $signed({temp_c[18], temp_c}) - $signed({3'b000, ti_c});
    if (t2w_c < ptc_pkg::TEMP_MIN) begin
      t2_c = ptc_pkg::TEMP_MIN[18:0];
    end else if (t2w_c > ptc_pkg::TEMP_MAX) begin
      t2_c = ptc_pkg::TEMP_MAX[18:0];
    end else begin
      t2_c = t2w_c[18:0];
    end
    qsq_c = q_3 * q_3;
    lsq_c = lo_c * lo_c;

    // stage 5: second-order offset and sensitivity terms
    sq3_c  = {3'b000, sq_4} + {2'b00, sq_4, 1'b0};
    sq5_c  = {3'b000, sq_4} + {1'b0, sq_4, 2'b00};
    lsq7_c = {lsq_4, 3'b000} - {3'b000, lsq_4};
    lsq4_c = {1'b0, lsq_4, 2'b00};
    if (low_4) begin
      offi_c  = (sq3_c >> 1) + (vlow_4 ? lsq7_c : 38'd0);
      sensi_c = (sq5_c >> 3) + (vlow_4 ? lsq4_c : 38'd0);
    end else begin
      offi_c  = {3'b000, sq_4} >> 4;
      sensi_c = '0;
    end

    // stage 7: split SENS2 for two narrow products
    s2lo_c = sens2_6[19:0];
    s2hi_c = sens2_6[38:20];

    // stage 8: recombine partial products
    prod_c = ($signed(64'(phi_7)) <<< 20) + $signed({20'h00000, plo_7});

    // stage 9: scale and remove offset
    diff_c = ptc_pkg::sdiv_pow2(64'(prod_8), 21) - 64'(off2_8);

    // stage 10: final scale and clamp
    pq_c = ptc_pkg::sdiv_pow2(64'(diff_9), 13);
    if (pq_c < ptc_pkg::PRES_MIN) begin
      p_c = ptc_pkg::PRES_MIN[31:0];
    end else if (pq_c > ptc_pkg::PRES_MAX) begin
      p_c = ptc_pkg::PRES_MAX[31:0];
    end else begin
      p_c = pq_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      d1_1 <= s_axis_tdata[23:0];
      dt_1 <= dt_c;
    end
    if (rdy[1]) begin
      d1_2   <= d1_1;
      mt_2   <= mt_c;
      mo_2   <= mo_c;
      ms_2   <= ms_c;
      dtsq_2 <= dtsq_c[47:0];
    end
    if (rdy[2]) begin
      d1_3   <= d1_2;
      q_3    <= 18'(ptc_pkg::sdiv_pow2(64'(mt_2), 23));
      off_3  <= $signed({4'h0, pressure_offset, 16'h0000})
              + 36'(ptc_pkg::sdiv_pow2(64'(mo_2), 7));
      sens_3 <= $signed({5'h00, pressure_sensitivity, 15'h0000})
              + 36'(ptc_pkg::sdiv_pow2(64'(ms_2), 8));
      tilo_3 <= ti3_c[49:33];
      tihi_3 <= {5'h00, dtsq_2[47:36]};
    end
    if (rdy[3]) begin
      d1_4   <= d1_3;
      off_4  <= off_3;
      sens_4 <= sens_3;
      t2_4   <= t2_c;
      sq_4   <= qsq_c[34:0];
      lsq_4  <= lsq_c[34:0];
      low_4  <= q_3[17];
      vlow_4 <= q_3 < ptc_pkg::VLOW_DT;
    end
    if (rdy[4]) begin
      d1_5    <= d1_4;
      off_5   <= off_4;
      sens_5  <= sens_4;
      t2_5    <= t2_4;
      offi_5  <= offi_c;
      sensi_5 <= sensi_c;
    end
    if (rdy[5]) begin
      d1_6    <= d1_5;
      t2_6    <= t2_5;
      off2_6  <= 40'(off_5) - $signed({2'b00, offi_5});
      sens2_6 <= 39'(40'(sens_5) - $signed({2'b00, sensi_5}));
    end
    if (rdy[6]) begin
      t2_7   <= t2_6;
      off2_7 <= off2_6;
      plo_7  <= d1_6 * s2lo_c;
      phi_7  <= $signed({1'b0, d1_6}) * s2hi_c;
    end
    if (rdy[7]) begin
      t2_8   <= t2_7;
      off2_8 <= off2_7;
      prod_8 <= prod_c[62:0];
    end
    if (rdy[8]) begin
      t2_9   <= t2_8;
      diff_9 <= diff_c[42:0];
    end
    if (rdy[9]) begin
      t2_10 <= t2_9;
      p_10  <= p_c;
    end
  end

  assign m_axis_tdata = {5'b00000, p_10, t2_10};

endmodule
`default_nettype wire

// ----- design/ptc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks on the compensation pipeline's handshakes.
// ----------------------------------------------------------------------------
module ptc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [ptc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // a waiting result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // a waiting result item keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // with the output draining, every stage moves and input is taken
  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output drains");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result item shown right after reset");

endmodule

bind pressure_temp_compensation ptc_checker u_ptc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
